// File: src/dfs_topological_order_assert.svh
// Assertion macros for the topological order block.
`ifndef DFS_TOPOLOGICAL_ORDER_ASSERT_SVH
`define DFS_TOPOLOGICAL_ORDER_ASSERT_SVH

`ifndef SYNTH
`define DFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfs_topological_order: assertion failed");
`define DFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfs_topological_order: assertion failed");
`else
`define DFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: src/dfs_topo_pkg.sv
package dfs_topo_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned VertexW = 6;
  localparam int unsigned CntW    = 7;
  localparam int unsigned StatusW = 2;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned MaxDegreeDef   = 16;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STAT_ORDER = 2'd0,
    STAT_OK    = 2'd1,
    STAT_DROP  = 2'd2
  } status_e;

  typedef struct packed {
    logic [VertexW-1:0] vertex_id;
    logic               last;
    logic [StatusW-1:0] status;
  } res_t;

endpackage

// File: src/dfs_topo_in_if.sv
interface dfs_topo_in_if;
  import dfs_topo_pkg::*;

  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [VertexW-1:0] from_vertex;
  logic [VertexW-1:0] to_vertex;

  modport source (output valid, kind, from_vertex, to_vertex, input ready);
  modport sink (input valid, kind, from_vertex, to_vertex, output ready);
endinterface

// File: src/dfs_topo_out_if.sv
interface dfs_topo_out_if;
  import dfs_topo_pkg::*;

  logic               valid;
  logic               ready;
  logic [VertexW-1:0] vertex_id;
  logic               last;
  logic [StatusW-1:0] status;

  modport source (output valid, vertex_id, last, status, input ready);
  modport sink (input valid, vertex_id, last, status, output ready);
endinterface

// File: src/dfs_topo_ram.sv
module dfs_topo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/dfs_topo_out_reg.sv
module dfs_topo_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dfs_topo_pkg::res_t  res_i,
  output logic                free_o,
  dfs_topo_out_if.source      out_o
);
  import dfs_topo_pkg::*;

  logic valid_q;
  logic valid_d;
  res_t data_q;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= res_i;
    end
  end

  assign free_o          = !valid_q || out_o.ready;
  assign out_o.valid     = valid_q;
  assign out_o.vertex_id = data_q.vertex_id;
  assign out_o.last      = data_q.last;
  assign out_o.status    = data_q.status;

endmodule

// File: src/dfs_topological_order.sv
// An edge load reads the degree RAM, then pushes its one item; a clear pushes its item at once.
// A run scans vertices in ST_SCAN, walks edges in ST_STEP_A/B and pops the stack in ST_POP,
// then emits items in ST_EMIT_A/B, paced by the registered reads of the RAMs.
// One item is in work at a time; the next is taken once the output register is free.
// Reset is asynchronous: vertex_count becomes MAX_VERTICES and all edge lists read as empty
// through per-vertex valid bits, so no clearing pass follows reset.
`include "dfs_topological_order_assert.svh"

module dfs_topological_order #(
  parameter int unsigned MAX_VERTICES = dfs_topo_pkg::MaxVerticesDef,
  parameter int unsigned MAX_DEGREE   = dfs_topo_pkg::MaxDegreeDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dfs_topo_pkg::CntW-1:0] cfg_wdata_i,
  dfs_topo_in_if.sink                   in_i,
  dfs_topo_out_if.source                out_o
);
  import dfs_topo_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_VERTICES);
  localparam int unsigned DW     = $clog2(MAX_DEGREE + 1);
  localparam int unsigned EDepth = MAX_VERTICES * MAX_DEGREE;
  localparam int unsigned EAW    = $clog2(EDepth);
  localparam int unsigned DepthW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SW     = AW + DW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LD_RD  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_STEP_A = 3'd3;
  localparam logic [2:0] ST_STEP_B = 3'd4;
  localparam logic [2:0] ST_POP    = 3'd5;
  localparam logic [2:0] ST_EMIT_A = 3'd6;
  localparam logic [2:0] ST_EMIT_B = 3'd7;

  logic [2:0]              state_q, state_d;
  logic [CntW-1:0]         vcnt_q, vcnt_d;
  logic [CntW-1:0]         v_q, v_d;
  logic [AW-1:0]           top_q, top_d;
  logic [DW-1:0]           cursor_q, cursor_d;
  logic [DepthW-1:0]       depth_q, depth_d;
  logic [DepthW-1:0]       fcount_q, fcount_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [MAX_VERTICES-1:0] degvld_q, degvld_d;
  logic [VertexW-1:0]      from_q, from_d;
  logic [VertexW-1:0]      to_q, to_d;

  logic [DepthW-1:0] depth_m1, depth_m2, fcount_m1;
  logic [AW-1:0]     from_idx, deg_idx, nxt_idx, vis_idx;
  logic [DW-1:0]     deg_eff, cursor_p1;
  logic [VertexW-1:0] nxt;
  logic              in_fire, out_free, res_push, load_ok, follow;
  res_t              res;

  logic              deg_we, deg_re;
  logic [AW-1:0]     deg_waddr, deg_raddr;
  logic [DW-1:0]     deg_wdata, deg_rdata;
  logic              edge_we, edge_re;
  logic [EAW-1:0]    edge_waddr, edge_raddr;
  logic [VertexW-1:0] edge_rdata;
  logic              stk_we, stk_re;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [SW-1:0]     stk_wdata, stk_rdata;
  logic              fin_we, fin_re;
  logic [AW-1:0]     fin_raddr;
  logic [VertexW-1:0] fin_rdata;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;

  assign depth_m1  = depth_q - 1'b1;
  assign depth_m2  = depth_q - DepthW'(2);
  assign fcount_m1 = fcount_q - 1'b1;
  assign from_idx  = from_q[AW-1:0];
  assign deg_idx   = (state_q == ST_LD_RD) ? from_idx : top_q;
  assign deg_eff   = degvld_q[deg_idx] ? deg_rdata : '0;
  assign cursor_p1 = cursor_q + 1'b1;
  assign nxt       = edge_rdata;
  assign nxt_idx   = nxt[AW-1:0];
  assign vis_idx   = (state_q == ST_SCAN) ? v_q[AW-1:0] : nxt_idx;

  assign load_ok = (CntW'(from_q) < vcnt_q) && (CntW'(to_q) < vcnt_q) &&
                   (deg_eff < DW'(MAX_DEGREE));
  assign follow  = (CntW'(nxt) < vcnt_q) && !visited_q[vis_idx] &&
                   (depth_q < DepthW'(MAX_VERTICES));

  assign edge_raddr = EAW'(top_q) * EAW'(MAX_DEGREE) + EAW'(cursor_q);
  assign edge_waddr = EAW'(from_idx) * EAW'(MAX_DEGREE) + EAW'(deg_eff);
  assign deg_waddr  = from_idx;
  assign deg_wdata  = deg_eff + 1'b1;
  assign stk_waddr  = depth_m1[AW-1:0];
  assign stk_wdata  = {top_q, cursor_p1};
  assign stk_raddr  = depth_m2[AW-1:0];
  assign fin_raddr  = fcount_m1[AW-1:0];

  always_comb begin
    if (cfg_wdata_i > CntW'(MAX_VERTICES)) begin
      vcnt_d = CntW'(MAX_VERTICES);
    end else if (cfg_wdata_i == '0) begin
      vcnt_d = CntW'(1);
    end else begin
      vcnt_d = cfg_wdata_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    v_d       = v_q;
    top_d     = top_q;
    cursor_d  = cursor_q;
    depth_d   = depth_q;
    fcount_d  = fcount_q;
    visited_d = visited_q;
    degvld_d  = degvld_q;
    from_d    = from_q;
    to_d      = to_q;
    deg_we    = 1'b0;
    deg_re    = 1'b0;
    deg_raddr = top_q;
    edge_we   = 1'b0;
    edge_re   = 1'b0;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    fin_we    = 1'b0;
    fin_re    = 1'b0;
    res_push  = 1'b0;
    res.vertex_id = from_q;
    res.last      = 1'b1;
    res.status    = STAT_OK;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.kind)
            KIND_APPEND: begin
              from_d    = in_i.from_vertex;
              to_d      = in_i.to_vertex;
              deg_re    = 1'b1;
              deg_raddr = in_i.from_vertex[AW-1:0];
              state_d   = ST_LD_RD;
            end
            KIND_RUN: begin
              visited_d = '0;
              depth_d   = '0;
              fcount_d  = '0;
              v_d       = '0;
              state_d   = ST_SCAN;
            end
            KIND_CLEAR: begin
              degvld_d      = '0;
              res_push      = 1'b1;
              res.vertex_id = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LD_RD: begin
        res_push   = 1'b1;
        res.status = load_ok ? STAT_OK : STAT_DROP;
        if (load_ok) begin
          edge_we            = 1'b1;
          deg_we             = 1'b1;
          degvld_d[from_idx] = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (v_q >= vcnt_q) begin
          state_d = ST_EMIT_A;
        end else begin
          v_d = v_q + 1'b1;
          if (!visited_q[vis_idx]) begin
            visited_d[vis_idx] = 1'b1;
            top_d    = v_q[AW-1:0];
            cursor_d = '0;
            depth_d  = DepthW'(1);
            state_d  = ST_STEP_A;
          end
        end
      end
      ST_STEP_A: begin
        deg_re  = 1'b1;
        edge_re = 1'b1;
        state_d = ST_STEP_B;
      end
      ST_STEP_B: begin
        if (cursor_q < deg_eff) begin
          cursor_d = cursor_p1;
          if (follow) begin
            stk_we             = 1'b1;
            visited_d[vis_idx] = 1'b1;
            top_d              = nxt_idx;
            cursor_d           = '0;
            depth_d            = depth_q + 1'b1;
          end
          state_d = ST_STEP_A;
        end else begin
          if (fcount_q < DepthW'(MAX_VERTICES)) begin
            fin_we   = 1'b1;
            fcount_d = fcount_q + 1'b1;
          end
          depth_d = depth_m1;
          if (depth_q == DepthW'(1)) begin
            state_d = ST_SCAN;
          end else begin
            stk_re  = 1'b1;
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        top_d    = stk_rdata[SW-1:DW];
        cursor_d = stk_rdata[DW-1:0];
        state_d  = ST_STEP_A;
      end
      ST_EMIT_A: begin
        fin_re   = 1'b1;
        fcount_d = fcount_m1;
        state_d  = ST_EMIT_B;
      end
      ST_EMIT_B: begin
        if (out_free) begin
          res_push      = 1'b1;
          res.vertex_id = fin_rdata;
          res.last      = (fcount_q == '0);
          res.status    = STAT_ORDER;
          state_d       = (fcount_q == '0) ? ST_IDLE : ST_EMIT_A;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vcnt_q    <= CntW'(MAX_VERTICES);
      v_q       <= '0;
      top_q     <= '0;
      cursor_q  <= '0;
      depth_q   <= '0;
      fcount_q  <= '0;
      visited_q <= '0;
      degvld_q  <= '0;
    end else begin
      state_q   <= state_d;
      vcnt_q    <= cfg_we_i ? vcnt_d : vcnt_q;
      v_q       <= v_d;
      top_q     <= top_d;
      cursor_q  <= cursor_d;
      depth_q   <= depth_d;
      fcount_q  <= fcount_d;
      visited_q <= visited_d;
      degvld_q  <= degvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    from_q <= from_d;
    to_q   <= to_d;
  end

  dfs_topo_ram #(.Width(VertexW), .Depth(EDepth)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (to_q),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  dfs_topo_ram #(.Width(DW), .Depth(MAX_VERTICES)) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .re_i    (deg_re),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

  dfs_topo_ram #(.Width(SW), .Depth(MAX_VERTICES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  dfs_topo_ram #(.Width(VertexW), .Depth(MAX_VERTICES)) u_finish_ram (
    .clk_i   (clk_i),
    .we_i    (fin_we),
    .waddr_i (fcount_q[AW-1:0]),
    .wdata_i (VertexW'(top_q)),
    .re_i    (fin_re),
    .raddr_i (fin_raddr),
    .rdata_o (fin_rdata)
  );

  dfs_topo_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  `DFS_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, res_push, !out_o.valid || out_o.ready)
  `DFS_ASSERT_IMPL(a_depth_bound, clk_i, rst_ni, 1'b1, depth_q <= DepthW'(MAX_VERTICES))
  `DFS_ASSERT_IMPL(a_walk_nonempty, clk_i, rst_ni, state_q == ST_STEP_A || state_q == ST_STEP_B || state_q == ST_POP, depth_q != '0)
  `DFS_ASSERT_IMPL(a_finish_bound, clk_i, rst_ni, state_q == ST_SCAN || state_q == ST_STEP_B, CntW'(fcount_q) <= vcnt_q)
  `DFS_ASSERT_NEXT(a_run_start, clk_i, rst_ni, in_fire && in_i.kind == KIND_RUN, state_q == ST_SCAN && fcount_q == '0)

endmodule

// File: sim/tb.sv
module tb;
  import dfs_topo_pkg::*;

  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [VertexW-1:0] src;
    logic [VertexW-1:0] dst;
  } graph_cmd_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;

  dfs_topo_in_if  in_if ();
  dfs_topo_out_if out_if ();

  dfs_topological_order uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  graph_cmd_t cmd_q[$];
  res_t       topo_out_q[$];
  graph_cmd_t next_cmd;

  int             vcount;
  int             deg [MaxVerticesDef];
  logic [VertexW-1:0] adj [MaxVerticesDef][MaxDegreeDef];

  int n_bad;
  int n_taken;
  int hold_left;
  int holds_done;
  logic calm;

  assign calm = (n_taken >= 100) && (n_taken < 180);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void expect_out(logic [VertexW-1:0] vid, logic lst, status_e st);
    res_t r;
    r.vertex_id = vid;
    r.last = lst;
    r.status = st;
    topo_out_q.push_back(r);
  endfunction

  function automatic void predict_order();
    bit                 seen [MaxVerticesDef];
    logic [VertexW-1:0] stk [MaxVerticesDef];
    int                 cur [MaxVerticesDef];
    logic [VertexW-1:0] fin[$];
    int                 sp;
    int                 top;
    int                 nxt;
    bit                 pushed;
    for (int v = 0; v < MaxVerticesDef; v++) seen[v] = 1'b0;
    for (int v = 0; v < vcount; v++) begin
      if (!seen[v]) begin
        seen[v] = 1'b1;
        stk[0] = VertexW'(v);
        cur[0] = 0;
        sp = 1;
        while (sp > 0) begin
          top = stk[sp-1];
          pushed = 1'b0;
          while (!pushed && cur[sp-1] < deg[top]) begin
            nxt = adj[top][cur[sp-1]];
            cur[sp-1]++;
            if (nxt < vcount && !seen[nxt]) begin
              seen[nxt] = 1'b1;
              stk[sp] = VertexW'(nxt);
              cur[sp] = 0;
              sp++;
              pushed = 1'b1;
            end
          end
          if (!pushed) begin
            fin.push_back(VertexW'(top));
            sp--;
          end
        end
      end
    end
    for (int i = fin.size() - 1; i >= 0; i--) begin
      expect_out(fin[i], i == 0, STAT_ORDER);
    end
  endfunction

  function automatic void graph_apply(graph_cmd_t c);
    case (c.kind)
      KIND_APPEND: begin
        if (c.src >= vcount || c.dst >= vcount || deg[c.src] >= MaxDegreeDef) begin
          expect_out(c.src, 1'b1, STAT_DROP);
        end else begin
          adj[c.src][deg[c.src]] = c.dst;
          deg[c.src]++;
          expect_out(c.src, 1'b1, STAT_OK);
        end
      end
      KIND_RUN: predict_order();
      KIND_CLEAR: begin
        for (int v = 0; v < MaxVerticesDef; v++) deg[v] = 0;
        expect_out('0, 1'b1, STAT_OK);
      end
      default: ;
    endcase
  endfunction

  task automatic flag_bad(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    n_bad++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      n_taken <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        graph_apply('{kind: in_if.kind, src: in_if.from_vertex, dst: in_if.to_vertex});
        n_taken <= n_taken + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
          next_cmd = cmd_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.kind <= next_cmd.kind;
          in_if.from_vertex <= next_cmd.src;
          in_if.to_vertex <= next_cmd.dst;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((n_taken == 200 && holds_done == 0) || (n_taken == 300 && holds_done == 1)) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (topo_out_q.size() == 0) begin
          flag_bad("unexpected item, vertex_id", out_if.vertex_id, -1);
        end else begin
          res_t want;
          want = topo_out_q.pop_front();
          if (out_if.vertex_id !== want.vertex_id)
            flag_bad("vertex_id", out_if.vertex_id, want.vertex_id);
          if (out_if.last !== want.last)
            flag_bad("last", out_if.last, want.last);
          if (out_if.status !== want.status)
            flag_bad("status", out_if.status, want.status);
        end
      end
      out_if.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 12);
    end
  end

  task automatic push_cmd(logic [KindW-1:0] k, int a, int b);
    cmd_q.push_back('{kind: k, src: a[VertexW-1:0], dst: b[VertexW-1:0]});
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || in_if.valid || topo_out_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_count(logic [CntW-1:0] val);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    if (val > MaxVerticesDef) vcount = MaxVerticesDef;
    else if (val == 0) vcount = 1;
    else vcount = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(logic [CntW-1:0] val, int n);
    int r;
    int a;
    int b;
    set_count(val);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        push_cmd(KIND_RUN, $urandom_range(63), $urandom_range(63));
      end else if (r < 8) begin
        push_cmd(KIND_CLEAR, $urandom_range(63), $urandom_range(63));
      end else if (r < 10) begin
        push_cmd(KIND_UNUSED, $urandom_range(63), $urandom_range(63));
      end else begin
        if ($urandom_range(9) != 0) begin
          a = $urandom_range(vcount - 1);
          b = $urandom_range(vcount - 1);
        end else begin
          a = $urandom_range(63);
          b = $urandom_range(63);
        end
        push_cmd(KIND_APPEND, a, b);
      end
    end
    push_cmd(KIND_RUN, 0, 0);
  endtask

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [CntW-1:0] sizes [12];
    in_if.valid = 1'b0;
    in_if.kind = '0;
    in_if.from_vertex = '0;
    in_if.to_vertex = '0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    n_bad = 0;
    vcount = MaxVerticesDef;
    for (int v = 0; v < MaxVerticesDef; v++) deg[v] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_cmd(KIND_UNUSED, 63, 63);
    push_cmd(KIND_RUN, 0, 0);
    push_cmd(KIND_APPEND, 0, 63);
    push_cmd(KIND_APPEND, 63, 0);
    push_cmd(KIND_APPEND, 63, 63);
    push_cmd(KIND_APPEND, 5, 2);
    push_cmd(KIND_APPEND, 5, 1);
    push_cmd(KIND_APPEND, 2, 5);
    push_cmd(KIND_APPEND, 42, 21);
    push_cmd(KIND_RUN, 0, 0);
    // Shrinking the count leaves edges that point past the last vertex.
    set_count(4);
    push_cmd(KIND_RUN, 0, 0);
    set_count(0);
    push_cmd(KIND_APPEND, 1, 0);
    push_cmd(KIND_APPEND, 0, 1);
    push_cmd(KIND_APPEND, 0, 0);
    push_cmd(KIND_RUN, 0, 0);
    push_cmd(KIND_CLEAR, 0, 0);
    set_count(127);
    push_cmd(KIND_RUN, 0, 0);
    push_cmd(KIND_APPEND, 21, 42);
    push_cmd(KIND_RUN, 0, 0);

    sizes = '{7'd64, 7'd3, 7'd16, 7'd127, 7'd1, 7'd40, 7'd0, 7'd65, 7'd8, 7'd63, 7'd2, 7'd64};
    foreach (sizes[i]) begin
      random_phase(sizes[i], 27);
    end
    random_phase(CntW'($urandom_range(1, 127)), 10);

    drain();
    repeat (30) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: dfs_topological_order.f
+incdir+src
src/dfs_topo_pkg.sv
src/dfs_topo_in_if.sv
src/dfs_topo_out_if.sv
src/dfs_topo_ram.sv
src/dfs_topo_out_reg.sv
src/dfs_topological_order.sv
sim/tb.sv
